// ===== hdl/psc_pkg.sv =====
// Package for the page signature compare block: configuration and stage types,
// register map, reset values and the relative tolerance test.
// Depends on nothing; used by every module under hdl.
package psc_pkg;

    // Register map, one 32-bit register every 4 bytes
    localparam int unsigned ADDR_W = 4;
    localparam logic [1:0] REG_REL_PERCENT      = 2'd0;
    localparam logic [1:0] REG_ABS_LIMIT        = 2'd1;
    localparam logic [1:0] REG_MAX_FAIL_BUCKETS = 2'd2;

    // Register reset values
    localparam logic [6:0]  REL_PERCENT_RESET      = 7'd5;
    localparam logic [15:0] ABS_LIMIT_RESET        = 16'd6;
    localparam logic [6:0]  MAX_FAIL_BUCKETS_RESET = 7'd3;

    // Saturation limits of the running totals
    localparam logic [6:0]  FAIL_MAX  = 7'd127;
    localparam logic [23:0] SCALE_MAX = 24'hFF_FFFF;
    localparam logic [23:0] DIFF_MAX  = 24'h7F_FFFF;
    localparam logic [23:0] DIFF_MIN  = 24'h80_0000;

    localparam logic [31:0] PERCENT_BASE = 32'd100;

    typedef struct packed {
        logic [6:0]  rel_percent;
        logic [15:0] abs_limit;
        logic [6:0]  max_fail_buckets;
    } psc_cfg_t;

    // One tested bucket pair, ready to accumulate
    typedef struct packed {
        logic               valid;
        logic               fail;
        logic signed [16:0] diff;
        logic [16:0]        scale;
        logic               last;
        logic               code_eq;
    } psc_bucket_t;

    // Totals of one finished signature, ready for the verdict
    typedef struct packed {
        logic               valid;
        logic [6:0]         fail_count;
        logic signed [23:0] sum_difference;
        logic [23:0]        sum_scale;
        logic               code_eq;
    } psc_total_t;

    // mag > 1 + floor(scale*percent/100)  is the same as  100*mag > scale*percent + 100
    function automatic logic exceeds_rel(input logic [23:0] mag, input logic [23:0] scale,
                                         input logic [6:0] percent);
        logic [31:0] lhs;
        logic [31:0] rhs;
        lhs = 32'(mag) * PERCENT_BASE;
        rhs = 32'(scale) * 32'(percent) + PERCENT_BASE;
        return lhs > rhs;
    endfunction

endpackage

// ===== hdl/psc_cfg_regs.sv =====
// Configuration registers of the page signature compare block behind an APB-style port.
// Depends on psc_pkg.
module psc_cfg_regs
    import psc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output psc_cfg_t          cfg
);

    psc_cfg_t cfg_reg;
    psc_cfg_t cfg_next;
    logic     wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    // Write the addressed register, drop writes beyond the map
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_REL_PERCENT:      cfg_next.rel_percent      = pwdata[6:0];
                REG_ABS_LIMIT:        cfg_next.abs_limit        = pwdata[15:0];
                REG_MAX_FAIL_BUCKETS: cfg_next.max_fail_buckets = pwdata[6:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rel_percent      <= REL_PERCENT_RESET;
            cfg_reg.abs_limit        <= ABS_LIMIT_RESET;
            cfg_reg.max_fail_buckets <= MAX_FAIL_BUCKETS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_idx)
            REG_REL_PERCENT:      prdata = {25'd0, cfg_reg.rel_percent};
            REG_ABS_LIMIT:        prdata = {16'd0, cfg_reg.abs_limit};
            REG_MAX_FAIL_BUCKETS: prdata = {25'd0, cfg_reg.max_fail_buckets};
            default:              prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/psc_bucket_test.sv =====
// Input register and per-bucket test: difference, sum and the fail decision of one pair.
// Depends on psc_pkg.
module psc_bucket_test
    import psc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  logic [15:0] bucket_a,
    input  logic [15:0] bucket_b,
    input  logic [9:0]  code_a,
    input  logic [9:0]  code_b,
    input  logic        last,
    input  psc_cfg_t    cfg,
    output psc_bucket_t bucket
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [15:0] a_reg;
    logic [15:0] b_reg;
    logic        last_reg;
    logic        code_eq_reg;

    logic               test_valid_reg;
    logic               test_valid_next;
    psc_bucket_t        test_reg;
    psc_bucket_t        test_next;
    logic signed [16:0] diff;
    logic [16:0]        mag_full;
    logic [15:0]        mag;
    logic [16:0]        scale;

    // Capture the word on acceptance
    assign in_valid_next = adv ? in_valid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            a_reg       <= bucket_a;
            b_reg       <= bucket_b;
            last_reg    <= last;
            code_eq_reg <= (code_a == code_b);
        end
    end

    // Form difference, sum and magnitude, then test against both limits
    always_comb
    begin
        diff     = $signed({1'b0, a_reg}) - $signed({1'b0, b_reg});
        scale    = {1'b0, a_reg} + {1'b0, b_reg};
        mag_full = diff[16] ? (17'd0 - diff) : diff;
        mag      = mag_full[15:0];

        test_next.valid   = in_valid_reg;
        test_next.fail    = exceeds_rel({8'd0, mag}, {7'd0, scale}, cfg.rel_percent)
                            || (mag > cfg.abs_limit);
        test_next.diff    = diff;
        test_next.scale   = scale;
        test_next.last    = last_reg;
        test_next.code_eq = code_eq_reg;
    end

    assign test_valid_next = adv ? in_valid_reg : test_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            test_valid_reg <= 1'b0;
        end
        else
        begin
            test_valid_reg <= test_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid_reg)
        begin
            test_reg <= test_next;
        end
    end

    always_comb
    begin
        bucket       = test_reg;
        bucket.valid = test_valid_reg;
    end

endmodule

// ===== hdl/psc_accum.sv =====
// Running totals of one signature: fail count, signed difference and scale, all saturating.
// Depends on psc_pkg.
module psc_accum
    import psc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  psc_bucket_t bucket,
    output psc_total_t  total
);

    logic [6:0]         fail_reg;
    logic [6:0]         fail_next;
    logic signed [23:0] diff_reg;
    logic signed [23:0] diff_next;
    logic [23:0]        scale_reg;
    logic [23:0]        scale_next;

    logic               total_valid_reg;
    logic               total_valid_next;
    psc_total_t         total_reg;
    psc_total_t         total_next;

    logic [6:0]         fail_sum;
    logic signed [24:0] diff_wide;
    logic signed [23:0] diff_sum;
    logic [24:0]        scale_wide;
    logic [23:0]        scale_sum;
    logic               take;

    assign take = adv && bucket.valid;

    // Add this pair and clamp each total
    always_comb
    begin
        fail_sum = (bucket.fail && (fail_reg != FAIL_MAX)) ? (fail_reg + 7'd1) : fail_reg;

        diff_wide = {diff_reg[23], diff_reg} + {{8{bucket.diff[16]}}, bucket.diff};
        unique case (diff_wide[24:23])
            2'b01:   diff_sum = DIFF_MAX;
            2'b10:   diff_sum = DIFF_MIN;
            default: diff_sum = diff_wide[23:0];
        endcase

        scale_wide = {1'b0, scale_reg} + {8'd0, bucket.scale};
        scale_sum  = scale_wide[24] ? SCALE_MAX : scale_wide[23:0];
    end

    // Hold totals, advance them on each pair, clear them after the final pair
    always_comb
    begin
        fail_next  = fail_reg;
        diff_next  = diff_reg;
        scale_next = scale_reg;
        if (take)
        begin
            if (bucket.last)
            begin
                fail_next  = 7'd0;
                diff_next  = 24'sd0;
                scale_next = 24'd0;
            end
            else
            begin
                fail_next  = fail_sum;
                diff_next  = diff_sum;
                scale_next = scale_sum;
            end
        end

        total_next.valid          = 1'b1;
        total_next.fail_count     = fail_sum;
        total_next.sum_difference = diff_sum;
        total_next.sum_scale      = scale_sum;
        total_next.code_eq        = bucket.code_eq;

        total_valid_next = adv ? (bucket.valid && bucket.last) : total_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_reg        <= 7'd0;
            diff_reg        <= 24'sd0;
            scale_reg       <= 24'd0;
            total_valid_reg <= 1'b0;
        end
        else
        begin
            fail_reg        <= fail_next;
            diff_reg        <= diff_next;
            scale_reg       <= scale_next;
            total_valid_reg <= total_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && bucket.last)
        begin
            total_reg <= total_next;
        end
    end

    always_comb
    begin
        total       = total_reg;
        total.valid = total_valid_reg;
    end

    // Totals restart from zero after a final pair
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        take && bucket.last |=> fail_reg == 7'd0 && diff_reg == 24'sd0 && scale_reg == 24'd0)
        else $error("totals not cleared after final pair");

    // Only a final pair produces totals for the verdict
    a_no_total_midway: assert property (@(posedge clk) disable iff (!rst_n)
        take && !bucket.last |=> !total_valid_reg)
        else $error("totals presented for a pair that is not final");

endmodule

// ===== hdl/psc_verdict.sv =====
// Verdict stage and result register: code match, fail budget and total relative test.
// Depends on psc_pkg.
module psc_verdict
    import psc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  psc_total_t total,
    input  psc_cfg_t   cfg,
    output logic       out_valid,
    output logic       same
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        same_reg;
    logic        same_next;
    logic [23:0] tmag;

    // Magnitude of the total difference; the most negative value maps to 2^23
    always_comb
    begin
        tmag      = total.sum_difference[23] ? (24'd0 - total.sum_difference)
                                             : total.sum_difference;
        same_next = total.code_eq
                    && (total.fail_count <= cfg.max_fail_buckets)
                    && !exceeds_rel(tmag, total.sum_scale, cfg.rel_percent);
        out_valid_next = adv ? total.valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && total.valid)
        begin
            same_reg <= same_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign same      = same_reg;

    // Differing status codes never give a match
    a_code_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
        adv && total.valid && !total.code_eq |=> out_valid_reg && !same_reg)
        else $error("match reported with differing status codes");

endmodule

// ===== hdl/page_signature_compare.sv =====
// Page signature compare: fuzzy histogram comparison, one bucket pair word per cycle.
// The final pair goes through the input, test and total registers into the result register.
// Throughput: one input word per cycle; the whole pipeline holds only while a result waits.
// Reset (rst_n, async, active low): pipeline and totals empty, registers to their defaults.
// Depends on psc_pkg, psc_cfg_regs, psc_bucket_test, psc_accum, psc_verdict.
module page_signature_compare
    import psc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [15:0]       bucket_a,
    input  logic [15:0]       bucket_b,
    input  logic [9:0]        code_a,
    input  logic [9:0]        code_b,
    input  logic              last,

    output logic              out_valid,
    input  logic              out_ready,
    output logic              same
);

    psc_cfg_t    cfg;
    psc_bucket_t bucket;
    psc_total_t  total;
    logic        adv;

    // Advance every stage unless a result word is waiting
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    psc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psc_bucket_test u_test (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .bucket_a (bucket_a),
        .bucket_b (bucket_b),
        .code_a   (code_a),
        .code_b   (code_b),
        .last     (last),
        .cfg      (cfg),
        .bucket   (bucket)
    );

    psc_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .bucket (bucket),
        .total  (total)
    );

    psc_verdict u_verdict (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .total     (total),
        .cfg       (cfg),
        .out_valid (out_valid),
        .same      (same)
    );

    // A waiting result word holds the input side
    a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while a result word is stalled");

endmodule

// ===== test/page_signature_compare_tb.sv =====
// Testbench for page_signature_compare: sends bucket pair words, writes the registers over APB
// and checks every verdict word against a local predictor of the signature comparison.
// Depends on psc_pkg and the page_signature_compare RTL.
module page_signature_compare_tb
    import psc_pkg::*;
();

    localparam int         HALF_PERIOD  = 5;
    localparam int         RESET_CYCLES = 4;
    localparam int         DRAIN_CYCLES = 8;     // well past the verdict latency
    localparam int         HOLD_CYCLES  = 300;
    localparam int         QUIET_LIMIT  = 5000;
    localparam int         SIG_BUCKETS  = 16;    // nominal signature length
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    // Saturation points of the running totals
    localparam longint RUN_DIFF_TOP    = 64'sd8388607;
    localparam longint RUN_DIFF_BOTTOM = -64'sd8388608;
    localparam longint RUN_SCALE_TOP   = 64'sd16777215;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [15:0]       bucket_a  = '0;
    logic [15:0]       bucket_b  = '0;
    logic [9:0]        code_a    = '0;
    logic [9:0]        code_b    = '0;
    logic              last      = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              same;

    // Idle rates and long-hold requests
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          hold_requests = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;

    // Predictor state and configuration shadow
    psc_cfg_t           shadow_cfg = '{rel_percent: REL_PERCENT_RESET,
                                       abs_limit: ABS_LIMIT_RESET,
                                       max_fail_buckets: MAX_FAIL_BUCKETS_RESET};
    logic [6:0]         fails_so_far = '0;
    logic signed [23:0] run_diff     = '0;
    logic [23:0]        run_scale    = '0;
    bit                 expected_same[$];

    int unsigned same_mismatches = 0;
    int unsigned quiet_cycles    = 0;
    bit          want_same;

    page_signature_compare i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .bucket_a  (bucket_a),
        .bucket_b  (bucket_b),
        .code_a    (code_a),
        .code_b    (code_b),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .same      (same)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold when one is requested
    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each verdict word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_same.size() == 0)
            begin
                $error("same: no verdict expected, actual %0d", same);
                same_mismatches = same_mismatches + 1;
            end
            else
            begin
                want_same = expected_same.pop_front();
                if (same !== want_same)
                begin
                    $error("same: expected %0d, actual %0d", want_same, same);
                    same_mismatches = same_mismatches + 1;
                end
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // True when a magnitude is beyond 1 + scale*percent/100
    function automatic bit over_tolerance(input longint mag, input longint scale);
        return mag > 1 + (scale * longint'(shadow_cfg.rel_percent)) / 100;
    endfunction

    // Fold one accepted bucket pair into the totals; predict the verdict on the last pair
    task automatic fold_pair(input logic [15:0] a, input logic [15:0] b, input logic [9:0] ca,
                             input logic [9:0] cb, input logic lst);
        longint diff;
        longint scale;
        longint mag;
        longint total;
        bit     verdict;
        diff  = longint'(a) - longint'(b);
        scale = longint'(a) + longint'(b);
        mag   = (diff < 0) ? -diff : diff;

        // count a failing bucket, holding at the top
        if ((over_tolerance(mag, scale) || mag > longint'(shadow_cfg.abs_limit))
            && fails_so_far != FAIL_MAX)
            fails_so_far = fails_so_far + 7'd1;

        total = longint'(run_diff) + diff;
        if (total > RUN_DIFF_TOP)
            total = RUN_DIFF_TOP;
        if (total < RUN_DIFF_BOTTOM)
            total = RUN_DIFF_BOTTOM;
        run_diff = total[23:0];

        total = longint'(run_scale) + scale;
        if (total > RUN_SCALE_TOP)
            total = RUN_SCALE_TOP;
        run_scale = total[23:0];

        if (lst)
        begin
            total = (run_diff < 0) ? -longint'(run_diff) : longint'(run_diff);
            verdict = (ca == cb) && (fails_so_far <= shadow_cfg.max_fail_buckets)
                      && !over_tolerance(total, longint'(run_scale));
            expected_same.push_back(verdict);
            fails_so_far = '0;
            run_diff     = '0;
            run_scale    = '0;
        end
    endtask

    // Offer one bucket pair word and hold it until accepted
    task automatic send_word(input logic [15:0] a, input logic [15:0] b, input logic [9:0] ca,
                             input logic [9:0] cb, input logic lst);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        bucket_a <= a;
        bucket_b <= b;
        code_a   <= ca;
        code_b   <= cb;
        last     <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        fold_pair(a, b, ca, cb, lst);
    endtask

    // Drop valid and wait until every verdict is back and the pipeline is empty
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_same.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_REL_PERCENT:      shadow_cfg.rel_percent      = value[6:0];
            REG_ABS_LIMIT:        shadow_cfg.abs_limit        = value[15:0];
            REG_MAX_FAIL_BUCKETS: shadow_cfg.max_fail_buckets = value[6:0];
            default:              ;
        endcase
    endtask

    task automatic set_idle(input int unsigned sender_pct, input int unsigned receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct <= receiver_pct;
    endtask

    // Pick a bucket pair: near-equal, near the tolerance, extremes or fully random
    task automatic pick_pair(output logic [15:0] a, output logic [15:0] b);
        int unsigned kind;
        longint      base;
        longint      delta;
        longint      lim;
        longint      other;
        kind  = $urandom_range(0, 9);
        base  = longint'($urandom_range(0, 65535));
        delta = 0;
        if (kind <= 3)
            delta = longint'($urandom_range(0, 8));
        else if (kind <= 5)
        begin
            base = longint'($urandom_range(0, 3000));
            lim  = 1 + (2 * base * longint'(shadow_cfg.rel_percent)) / 100;
            if (lim > longint'(shadow_cfg.abs_limit))
                lim = longint'(shadow_cfg.abs_limit);
            delta = lim + longint'($urandom_range(0, 2)) - 1;
        end
        else if (kind == 6)
            delta = longint'($urandom_range(0, 65535));
        else if (kind == 7)
        begin
            base  = longint'($urandom_range(0, 1)) * 65535;
            delta = longint'($urandom_range(0, 1)) * 65535;
        end
        other = ($urandom_range(0, 1) != 0) ? base + delta : base - delta;
        if (other < 0)
            other = 0;
        if (other > 65535)
            other = 65535;
        if ($urandom_range(0, 1) != 0)
        begin
            a = base[15:0];
            b = other[15:0];
        end
        else
        begin
            a = other[15:0];
            b = base[15:0];
        end
    endtask

    function automatic int random_len();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return $urandom_range(1, SIG_BUCKETS);
        if (pick < 9)
            return $urandom_range(SIG_BUCKETS + 1, 40);
        return 1;
    endfunction

    // Send one signature of random pairs; codes match on the last pair most of the time
    task automatic send_signature(input int len);
        logic [15:0] a;
        logic [15:0] b;
        logic [9:0]  ca;
        logic [9:0]  cb;
        for (int k = 0; k < len; k++)
        begin
            pick_pair(a, b);
            ca = 10'($urandom_range(0, 999));
            if (k == len - 1)
                cb = ($urandom_range(0, 4) != 0) ? ca : 10'($urandom_range(0, 999));
            else
                cb = ($urandom_range(0, 1) != 0) ? ca : 10'($urandom_range(0, 999));
            send_word(a, b, ca, cb, k == len - 1);
        end
    endtask

    task automatic randomize_config();
        logic [31:0] rel;
        logic [31:0] lim;
        logic [31:0] cap;
        case ($urandom_range(0, 3))
            0:       rel = 32'd0;
            1:       rel = 32'd100;
            2:       rel = 32'd127;
            default: rel = $urandom_range(0, 100);
        endcase
        case ($urandom_range(0, 3))
            0:       lim = 32'd0;
            1:       lim = 32'd65535;
            2:       lim = $urandom_range(0, 200);
            default: lim = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 3))
            0:       cap = 32'd0;
            1:       cap = 32'd64;
            2:       cap = 32'd127;
            default: cap = $urandom_range(0, 8);
        endcase
        write_reg(REG_REL_PERCENT, rel);
        write_reg(REG_ABS_LIMIT, lim);
        write_reg(REG_MAX_FAIL_BUCKETS, cap);
    endtask

    // Extremes, code handling, early failure and the fail-count limit at reset settings
    task automatic test_directed();
        send_word(16'd0, 16'd0, 10'd200, 10'd200, 1'b1);
        send_word(16'hFFFF, 16'd0, 10'd200, 10'd200, 1'b1);
        send_word(16'd0, 16'hFFFF, 10'd999, 10'd999, 1'b1);
        send_word(16'hFFFF, 16'hFFFF, 10'd0, 10'd0, 1'b1);
        // absolute limit: a difference of 6 passes, 7 fails
        send_word(16'd100, 16'd106, 10'd301, 10'd301, 1'b1);
        send_word(16'd100, 16'd107, 10'd301, 10'd301, 1'b1);
        // codes differ before the last pair only
        send_word(16'd10, 16'd10, 10'd200, 10'd404, 1'b0);
        send_word(16'd10, 16'd10, 10'd200, 10'd200, 1'b1);
        // codes differ on the last pair only
        send_word(16'd5, 16'd5, 10'd302, 10'd302, 1'b0);
        send_word(16'd5, 16'd5, 10'd302, 10'd303, 1'b1);
        // early failing bucket, verdict still at the end
        send_word(16'd1000, 16'd0, 10'd200, 10'd200, 1'b0);
        send_word(16'd20, 16'd20, 10'd200, 10'd200, 1'b0);
        send_word(16'd20, 16'd20, 10'd200, 10'd200, 1'b0);
        send_word(16'd20, 16'd20, 10'd200, 10'd200, 1'b1);
        // exactly the allowed number of failing buckets
        send_word(16'd1000, 16'd1010, 10'd200, 10'd200, 1'b0);
        send_word(16'd1010, 16'd1000, 10'd200, 10'd200, 1'b0);
        send_word(16'd1000, 16'd1010, 10'd200, 10'd200, 1'b0);
        send_word(16'd1000, 16'd1000, 10'd200, 10'd200, 1'b1);
        // one failing bucket too many
        send_word(16'd1000, 16'd1010, 10'd200, 10'd200, 1'b0);
        send_word(16'd1010, 16'd1000, 10'd200, 10'd200, 1'b0);
        send_word(16'd1000, 16'd1010, 10'd200, 10'd200, 1'b0);
        send_word(16'd1010, 16'd1000, 10'd200, 10'd200, 1'b1);
    endtask

    // Register extremes, out-of-range values, high garbage bits and an unmapped address
    task automatic test_registers();
        drain_results();
        write_reg(REG_REL_PERCENT, 32'd0);
        write_reg(REG_ABS_LIMIT, 32'd0);
        write_reg(REG_MAX_FAIL_BUCKETS, 32'd0);
        repeat (6) send_signature(random_len());
        drain_results();
        write_reg(REG_REL_PERCENT, 32'd100);
        write_reg(REG_ABS_LIMIT, 32'd65535);
        write_reg(REG_MAX_FAIL_BUCKETS, 32'd64);
        repeat (6) send_signature(random_len());
        drain_results();
        write_reg(REG_REL_PERCENT, 32'hFFFF_FFFF);
        write_reg(REG_ABS_LIMIT, 32'hABCD_FFFF);
        write_reg(REG_MAX_FAIL_BUCKETS, 32'h5A5A_5A7F);
        write_reg(REG_UNMAPPED, 32'h0000_0000);
        repeat (6) send_signature(random_len());
    endtask

    task automatic send_run(input int count, input logic [15:0] a, input logic [15:0] b,
                            input logic lst);
        for (int k = 0; k < count; k++)
            send_word(a, b, 10'd500, 10'd500, lst && k == count - 1);
    endtask

    // Long signatures that drive every running total into saturation
    task automatic test_saturation();
        drain_results();
        write_reg(REG_REL_PERCENT, 32'd100);
        write_reg(REG_MAX_FAIL_BUCKETS, 32'd127);
        send_run(200, 16'hFFFF, 16'd0, 1'b1);
        send_run(150, 16'd0, 16'hFFFF, 1'b0);
        send_run(100, 16'hFFFF, 16'd0, 1'b1);
        drain_results();
        write_reg(REG_REL_PERCENT, 32'd20);
        write_reg(REG_MAX_FAIL_BUCKETS, 32'd126);
        send_run(200, 16'hFFFF, 16'd0, 1'b1);
        send_run(260, 16'hFFFF, 16'hFFFF, 1'b1);
        send_run(150, 16'd0, 16'hFFFF, 1'b0);
        send_run(100, 16'hFFFF, 16'd0, 1'b1);
    endtask

    // Hold the receiver off while short signatures keep coming, so the input stalls
    task automatic test_backpressure();
        drain_results();
        randomize_config();
        hold_requests <= hold_requests + 1;
        repeat (40) send_signature($urandom_range(1, 2));
    endtask

    task automatic test_random(input int phases, input int words_per_phase);
        int sent;
        int len;
        for (int p = 0; p < phases; p++)
        begin
            drain_results();
            randomize_config();
            sent = 0;
            while (sent < words_per_phase)
            begin
                len = random_len();
                send_signature(len);
                sent = sent + len;
            end
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(37, 48);
        test_directed();
        test_registers();
        test_saturation();
        test_backpressure();
        test_random(2, 30);

        set_idle(48, 37);
        test_random(2, 30);

        set_idle(0, 0);
        test_random(2, 30);

        drain_results();
        if (same_mismatches == 0 && expected_same.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
